// ===== design/hpvd_pkg.sv =====
// Shared types, constants and the rounding/saturation helper for the
// Horner value/derivative pipeline. No dependencies.
package hpvd_pkg;

    localparam int DATA_W        = 32;
    localparam int PROD_W        = 64;
    localparam int FRAC_W        = 16;
    localparam int ORDER_W       = 3;
    localparam int CFG_IDX_W     = 4;
    localparam int MAX_ORDER_DEF = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLY_ORDER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_SEL  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEF0      = CFG_IDX_W'(2);

    // Operands of one Horner step, before the multiply
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] d;
        logic                     vflag;
        logic                     dflag;
        logic                     last;
    } stage_t;

    // Products of one Horner step, before round, add and clamp
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] d;
        logic signed [PROD_W-1:0] prod_v;
        logic signed [PROD_W-1:0] prod_d;
        logic                     vflag;
        logic                     dflag;
        logic                     last;
    } mul_t;

    // Round Q32.32 to Q16.16 (half up), add c, clamp to 32 bits.
    // Returns {clamped, value}.
    function automatic logic [DATA_W:0] rnd_add_sat(
        input logic signed [PROD_W-1:0] prod,
        input logic signed [DATA_W-1:0] c
    );
        logic signed [PROD_W-1:0]        biased;
        logic signed [PROD_W-FRAC_W-1:0] rnd;
        logic signed [PROD_W-FRAC_W:0]   sum;
        logic                            ovf;
        logic        [DATA_W-1:0]        res;
        biased = prod + PROD_W'(64'sd1 <<< (FRAC_W - 1));
        rnd    = biased[PROD_W-1:FRAC_W];
        sum    = (PROD_W-FRAC_W+1)'(rnd) + (PROD_W-FRAC_W+1)'(c);
        // in range when all bits above the 32-bit sign agree with it
        ovf    = !((&sum[PROD_W-FRAC_W:DATA_W-1]) || !(|sum[PROD_W-FRAC_W:DATA_W-1]));
        if (!ovf) begin
            res = sum[DATA_W-1:0];
        end
        else if (sum[PROD_W-FRAC_W]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return {ovf, res};
    endfunction

endpackage

// ===== design/horner_poly_value_derivative.sv =====
// Top level: pipelined Horner evaluator of a Q16.16 polynomial and its
// first derivative. Depends on hpvd_pkg.
//
// Usage:
//   Input channel: present sample_x and last_sample with start high; the
//   transaction is taken at any rising edge where start is high and busy is
//   low. busy never rises, so a new sample may enter every cycle.
//   Result channel: value_out, overflow and last_out are valid for exactly
//   one cycle while done is high. The receiver cannot stall; results appear
//   in input order, one per sample.
//   Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
//   cfg_ready is always high. Index 0 poly_order, 1 derivative_select,
//   2..7 coef0..coef5; other indexes are ignored. Write only while idle.
// Pipeline: one multiply stage and one round/add/clamp stage per Horner step,
//   plus the input and output registers. Throughput: one sample per cycle.
// Reset: poly_order = 1, derivative_select = 0, coefficients 0, pipeline
//   emptied; no result is produced for anything in flight at reset.
module horner_poly_value_derivative #(
    parameter int MAX_ORDER = hpvd_pkg::MAX_ORDER_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [hpvd_pkg::DATA_W-1:0]   sample_x,
    input  logic                                 last_sample,
    // result channel
    output logic                                 done,
    output logic signed [hpvd_pkg::DATA_W-1:0]   value_out,
    output logic                                 overflow,
    output logic                                 last_out,
    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [hpvd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [hpvd_pkg::DATA_W-1:0]   cfg_data
);

    localparam int NUM_COEFS = MAX_ORDER + 1;
    localparam int CIDX_W    = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;

    // configuration registers
    logic        [hpvd_pkg::ORDER_W-1:0] poly_order_reg;
    logic                                deriv_sel_reg;
    logic signed [hpvd_pkg::DATA_W-1:0]  coef_reg [NUM_COEFS];

    logic        [hpvd_pkg::ORDER_W-1:0] eff_order;

    // pipeline registers
    hpvd_pkg::stage_t stage_reg [MAX_ORDER+1];
    logic             stage_vld_reg [MAX_ORDER+1];
    hpvd_pkg::mul_t   mul_reg [MAX_ORDER];
    logic             mul_vld_reg [MAX_ORDER];

    hpvd_pkg::stage_t stage0_next;

    logic signed [hpvd_pkg::DATA_W-1:0] value_out_reg;
    logic                               overflow_reg;
    logic                               last_out_reg;
    logic                               done_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            poly_order_reg <= hpvd_pkg::ORDER_W'(1);
            deriv_sel_reg  <= 1'b0;
            for (int k = 0; k < NUM_COEFS; k++) begin
                coef_reg[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready) begin
            if (cfg_index == hpvd_pkg::REG_POLY_ORDER) begin
                poly_order_reg <= cfg_data[hpvd_pkg::ORDER_W-1:0];
            end
            if (cfg_index == hpvd_pkg::REG_DERIV_SEL) begin
                deriv_sel_reg <= cfg_data[0];
            end
            for (int k = 0; k < NUM_COEFS; k++) begin
                if (cfg_index == hpvd_pkg::REG_COEF0 + hpvd_pkg::CFG_IDX_W'(k)) begin
                    coef_reg[k] <= cfg_data;
                end
            end
        end
    end

    // clamp order into 1..MAX_ORDER
    always_comb begin
        if (poly_order_reg == '0) begin
            eff_order = hpvd_pkg::ORDER_W'(1);
        end
        else if (poly_order_reg > hpvd_pkg::ORDER_W'(MAX_ORDER)) begin
            eff_order = hpvd_pkg::ORDER_W'(MAX_ORDER);
        end
        else begin
            eff_order = poly_order_reg;
        end
    end

    // input stage: seed value chain with the leading coefficient
    always_comb begin
        stage0_next.x     = sample_x;
        stage0_next.v     = coef_reg[eff_order[CIDX_W-1:0]];
        stage0_next.d     = '0;
        stage0_next.vflag = 1'b0;
        stage0_next.dflag = 1'b0;
        stage0_next.last  = last_sample;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            stage_vld_reg[0] <= 1'b0;
        end
        else begin
            stage_vld_reg[0] <= start && !busy;
        end
    end

    always_ff @(posedge clk) begin
        stage_reg[0] <= stage0_next;
    end

    // Horner step k handles coefficient index MAX_ORDER-1-k; steps whose index is at or
    // above the effective order pass their operands through untouched.
    for (genvar k = 0; k < MAX_ORDER; k++) begin : g_step
        localparam int J = MAX_ORDER - 1 - k;

        hpvd_pkg::mul_t   mul_next;
        hpvd_pkg::stage_t add_next;
        logic             active;
        logic [hpvd_pkg::DATA_W:0] vres;
        logic [hpvd_pkg::DATA_W:0] dres;

        always_comb begin
            mul_next.x      = stage_reg[k].x;
            mul_next.v      = stage_reg[k].v;
            mul_next.d      = stage_reg[k].d;
            mul_next.prod_v = hpvd_pkg::PROD_W'($signed(stage_reg[k].v))
                            * hpvd_pkg::PROD_W'($signed(stage_reg[k].x));
            mul_next.prod_d = hpvd_pkg::PROD_W'($signed(stage_reg[k].d))
                            * hpvd_pkg::PROD_W'($signed(stage_reg[k].x));
            mul_next.vflag  = stage_reg[k].vflag;
            mul_next.dflag  = stage_reg[k].dflag;
            mul_next.last   = stage_reg[k].last;
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                mul_vld_reg[k] <= 1'b0;
            end
            else begin
                mul_vld_reg[k] <= stage_vld_reg[k];
            end
        end

        always_ff @(posedge clk) begin
            mul_reg[k] <= mul_next;
        end

        assign active = (eff_order > hpvd_pkg::ORDER_W'(J));

        always_comb begin
            // derivative uses the value before this step's update
            dres = hpvd_pkg::rnd_add_sat($signed(mul_reg[k].prod_d), $signed(mul_reg[k].v));
            vres = hpvd_pkg::rnd_add_sat($signed(mul_reg[k].prod_v), coef_reg[J]);
            add_next.x    = mul_reg[k].x;
            add_next.last = mul_reg[k].last;
            if (active) begin
                add_next.v     = vres[hpvd_pkg::DATA_W-1:0];
                add_next.d     = dres[hpvd_pkg::DATA_W-1:0];
                add_next.vflag = mul_reg[k].vflag | vres[hpvd_pkg::DATA_W];
                add_next.dflag = mul_reg[k].dflag | dres[hpvd_pkg::DATA_W];
            end
            else begin
                add_next.v     = mul_reg[k].v;
                add_next.d     = mul_reg[k].d;
                add_next.vflag = mul_reg[k].vflag;
                add_next.dflag = mul_reg[k].dflag;
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                stage_vld_reg[k+1] <= 1'b0;
            end
            else begin
                stage_vld_reg[k+1] <= mul_vld_reg[k];
            end
        end

        always_ff @(posedge clk) begin
            stage_reg[k+1] <= add_next;
        end
    end

    // output register: pick the selected chain
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= stage_vld_reg[MAX_ORDER];
        end
    end

    always_ff @(posedge clk) begin
        if (deriv_sel_reg) begin
            value_out_reg <= stage_reg[MAX_ORDER].d;
            overflow_reg  <= stage_reg[MAX_ORDER].dflag;
        end
        else begin
            value_out_reg <= stage_reg[MAX_ORDER].v;
            overflow_reg  <= stage_reg[MAX_ORDER].vflag;
        end
        last_out_reg <= stage_reg[MAX_ORDER].last;
    end

    assign done      = done_reg;
    assign value_out = value_out_reg;
    assign overflow  = overflow_reg;
    assign last_out  = last_out_reg;

endmodule

// ===== tb/sv/hpvd_result_checker.sv =====
`timescale 1ns / 100ps
// Checker for the Horner value/derivative block: tracks register writes,
// predicts one result per accepted sample and compares it. Depends on hpvd_pkg.
module hpvd_result_checker
    import hpvd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic signed [DATA_W-1:0] sample_x,
    input  logic                     last_sample,
    input  logic                     done,
    input  logic signed [DATA_W-1:0] value_out,
    input  logic                     overflow,
    input  logic                     last_out,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    output int                       fail_count,
    output int                       pending
);

    localparam int NUM_COEFS = MAX_ORDER_DEF + 1;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     ovf;
        logic                     last;
    } poly_result_t;

    logic        [ORDER_W-1:0] cur_order;
    logic                      cur_deriv;
    logic signed [DATA_W-1:0]  cur_coef [0:NUM_COEFS-1];

    poly_result_t eval_queue [$];
    poly_result_t want;
    int           mismatches = 0;

    // a * x rounded half up back to Q16.16, plus c, clamped to 32 bits
    function automatic longint mul_round_sat(input longint a, input longint xv,
                                             input longint c, inout bit clamped);
        longint prod;
        longint sum;
        prod = a * xv;
        sum  = ((prod + 64'sd32768) >>> FRAC_W) + c;
        if (sum > Q_MAX) begin
            clamped = 1'b1;
            return Q_MAX;
        end
        if (sum < Q_MIN) begin
            clamped = 1'b1;
            return Q_MIN;
        end
        return sum;
    endfunction

    function automatic poly_result_t horner_eval(input logic signed [DATA_W-1:0] x,
                                                 input logic last);
        int           order;
        longint       xv;
        longint       v;
        longint       d;
        bit           v_clamp;
        bit           d_clamp;
        poly_result_t r;
        order = int'(cur_order);
        if (order < 1) order = 1;
        if (order > MAX_ORDER_DEF) order = MAX_ORDER_DEF;
        xv      = longint'(x);
        v       = longint'(cur_coef[order]);
        d       = 0;
        v_clamp = 1'b0;
        d_clamp = 1'b0;
        for (int j = order - 1; j >= 0; j--) begin
            d = mul_round_sat(d, xv, v, d_clamp);
            v = mul_round_sat(v, xv, longint'(cur_coef[j]), v_clamp);
        end
        r.value = cur_deriv ? DATA_W'(d) : DATA_W'(v);
        r.ovf   = cur_deriv ? d_clamp : v_clamp;
        r.last  = last;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cur_order = ORDER_W'(1);
            cur_deriv = 1'b0;
            for (int k = 0; k < NUM_COEFS; k++) cur_coef[k] = '0;
            eval_queue.delete();
            pending <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_POLY_ORDER) begin
                    cur_order = cfg_data[ORDER_W-1:0];
                end
                else if (cfg_index == REG_DERIV_SEL) begin
                    cur_deriv = cfg_data[0];
                end
                else if (cfg_index >= REG_COEF0 && cfg_index < REG_COEF0 + NUM_COEFS) begin
                    cur_coef[cfg_index - REG_COEF0] = cfg_data;
                end
                // higher indexes are dropped
            end
            if (start && !busy) begin
                eval_queue.push_back(horner_eval(sample_x, last_sample));
            end
            if (done) begin
                if (eval_queue.size() == 0) begin
                    $display("%0t: result with none expected: value_out %h overflow %b last_out %b",
                             $time, value_out, overflow, last_out);
                    mismatches++;
                end
                else begin
                    want = eval_queue.pop_front();
                    if (value_out !== want.value) begin
                        $display("%0t: value_out mismatch: expected %h actual %h",
                                 $time, want.value, value_out);
                        mismatches++;
                    end
                    if (overflow !== want.ovf) begin
                        $display("%0t: overflow mismatch: expected %b actual %b",
                                 $time, want.ovf, overflow);
                        mismatches++;
                    end
                    if (last_out !== want.last) begin
                        $display("%0t: last_out mismatch: expected %b actual %b",
                                 $time, want.last, last_out);
                        mismatches++;
                    end
                end
            end
            pending <= eval_queue.size();
        end
        fail_count <= mismatches;
    end

endmodule

// ===== tb/sv/horner_poly_value_derivative_test.sv =====
`timescale 1ns / 100ps
// Top of the Horner value/derivative testbench: clock, reset, sample and
// register stimulus, verdict. Depends on hpvd_pkg and hpvd_result_checker.
module horner_poly_value_derivative_test;

    import hpvd_pkg::*;

    localparam int NUM_COEFS    = MAX_ORDER_DEF + 1;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 930;
    localparam int DRAIN_CYCLES = 2 * MAX_ORDER_DEF + 6;
    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] sample_x;
    logic                     last_sample;
    logic                     done;
    logic signed [DATA_W-1:0] value_out;
    logic                     overflow;
    logic                     last_out;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    int                       fail_count;
    int                       pending;
    int                       cycle_count = 0;

    // register settings for the next load
    logic [ORDER_W-1:0] plan_order;
    logic               plan_deriv;
    logic [DATA_W-1:0]  plan_coef [0:NUM_COEFS-1];

    horner_poly_value_derivative #(
        .MAX_ORDER(MAX_ORDER_DEF)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .sample_x   (sample_x),
        .last_sample(last_sample),
        .done       (done),
        .value_out  (value_out),
        .overflow   (overflow),
        .last_out   (last_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    hpvd_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .sample_x   (sample_x),
        .last_sample(last_sample),
        .done       (done),
        .value_out  (value_out),
        .overflow   (overflow),
        .last_out   (last_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] edge_sample(input int k);
        case (k)
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return Q_ONE;
            6:       return 32'hFFFF_0000;
            7:       return 32'h0000_8000;
            default: return 32'hFFFF_8000;
        endcase
    endfunction

    // mostly small abscissas so that results stay in range, some wide ones
    function automatic logic [DATA_W-1:0] rand_sample();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) return edge_sample($urandom_range(0, 8));
        if (kind <= 2) return $urandom;
        if (kind <= 4) return DATA_W'(int'($urandom_range(0, 128 * 65536)) - 64 * 65536);
        return DATA_W'(int'($urandom_range(0, 4 * 65536)) - 2 * 65536);
    endfunction

    function automatic logic [DATA_W-1:0] rand_coef();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) return 32'h8000_0000;
        if (kind == 1) return 32'h7FFF_FFFF;
        if (kind <= 3) return $urandom;
        return DATA_W'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
    endfunction

    function automatic int pick_gap(input bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_sample(input logic [DATA_W-1:0] x, input logic last, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        sample_x    <= x;
        last_sample <= last;
        do @(posedge clk); while (busy);
    endtask

    // hold off new samples until every expected result has come back
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_config(input bit stray);
        write_reg(REG_POLY_ORDER, ($urandom & ~32'h7) | DATA_W'(plan_order));
        write_reg(REG_DERIV_SEL, ($urandom & ~32'h1) | DATA_W'(plan_deriv));
        for (int k = 0; k < NUM_COEFS; k++) begin
            write_reg(CFG_IDX_W'(REG_COEF0 + k), plan_coef[k]);
        end
        // writes past the last coefficient must change nothing
        if (stray) begin
            write_reg(CFG_IDX_W'($urandom_range(REG_COEF0 + NUM_COEFS, 2**CFG_IDX_W - 1)),
                      $urandom);
            write_reg(CFG_IDX_W'(2**CFG_IDX_W - 1), 32'hFFFF_FFFF);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int  total;
        int  phase;
        int  phase_len;
        bit  burst;
        start       <= 1'b0;
        sample_x    <= '0;
        last_sample <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: all coefficients zero
        send_sample(32'h7FFF_FFFF, 1'b1, 0);
        send_sample(32'h8000_0000, 1'b0, 1);
        wait_idle();

        // order zero behaves as order one; extreme coefficients, edge abscissas
        plan_order = ORDER_W'(0);
        plan_deriv = 1'b0;
        plan_coef[0] = 32'h8000_0000;
        plan_coef[1] = 32'h7FFF_FFFF;
        for (int k = 2; k < NUM_COEFS; k++) plan_coef[k] = $urandom;
        load_config(1'b0);
        for (int k = 0; k < 9; k++) send_sample(edge_sample(k), k[0], pick_gap(1'b0));
        wait_idle();

        // order above the maximum clamps to it; derivative of all-max polynomial
        plan_order = ORDER_W'(7);
        plan_deriv = 1'b1;
        for (int k = 0; k < NUM_COEFS; k++) plan_coef[k] = 32'h7FFF_FFFF;
        load_config(1'b0);
        send_sample(Q_ONE, 1'b0, 0);
        send_sample(32'hFFFF_0000, 1'b1, 0);
        send_sample(32'h8000_0000, 1'b0, 2);
        send_sample(32'h0000_0001, 1'b1, 0);
        wait_idle();

        plan_order = ORDER_W'(6);
        plan_deriv = 1'b0;
        for (int k = 0; k < NUM_COEFS; k++) plan_coef[k] = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
        load_config(1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 0);
        send_sample(32'hFFFF_8000, 1'b1, 0);
        send_sample(32'h0000_8000, 1'b0, 0);
        send_sample(32'h0000_0000, 1'b1, 3);
        wait_idle();

        // full order, derivative, with writes to unused indexes
        plan_order = ORDER_W'(5);
        plan_deriv = 1'b1;
        for (int k = 0; k < NUM_COEFS; k++) plan_coef[k] = rand_coef();
        load_config(1'b1);
        send_sample(Q_ONE, 1'b0, 0);
        send_sample(32'h0002_0000, 1'b1, 0);
        send_sample(32'hFFFE_8000, 1'b0, 0);
        send_sample(rand_sample(), 1'b1, 0);

        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            wait_idle();
            plan_order = ORDER_W'($urandom_range(1, 5));
            if ($urandom_range(0, 5) == 0) plan_order = ORDER_W'($urandom_range(0, 1) ? 0 : $urandom_range(6, 7));
            plan_deriv = 1'($urandom_range(0, 1));
            for (int k = 0; k < NUM_COEFS; k++) plan_coef[k] = rand_coef();
            load_config($urandom_range(0, 3) == 0);
            burst     = ($urandom_range(0, 2) == 0);
            phase_len = $urandom_range(20, 60);
            for (int n = 0; n < phase_len; n++) begin
                if (phase == 1 && n == phase_len / 2) wait_idle();
                send_sample(rand_sample(), $urandom_range(0, 7) == 0, pick_gap(burst));
            end
            total += phase_len;
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end
        else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
